// ===== hw/rtl/tup_pkg.sv =====
// Shared types and constants for the tile unswizzle and palette expansion block.
// No dependencies; every other file of the block imports this package.
package tup_pkg;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned TW_W    = 6;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned MAX_TILE_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_PIXEL     = 2'd1,
    OP_RESTART   = 2'd2
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDX8 = 2'd0,
    MODE_IDX4 = 2'd1,
    MODE_RGBA = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_TILE_WIDTH    = 3'd2,
    REG_PIXEL_MODE    = 3'd3,
    REG_PALETTE_COUNT = 3'd4
  } reg_idx_e;

  // Control from the result stage to the walk counters.
  typedef struct packed {
    logic load;
    logic restart;
  } walk_ctrl_t;

  // Current walk position as seen by the next pixel.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               visible;
  } walk_pos_t;

endpackage

// ===== hw/rtl/tup_if.sv =====
// Valid/ready channel interfaces for the input items and the pixel results.
// Depends on tup_pkg for the field widths.
interface tup_in_if import tup_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [BYTE_W-1:0]   palette_slot;
  logic [BYTE_W-1:0]   pixel_byte;
  logic [COLOR_W-1:0]  color_word;

  modport source (output valid, operation, palette_slot, pixel_byte, color_word,
                  input ready);
  modport sink   (input valid, operation, palette_slot, pixel_byte, color_word,
                  output ready);
endinterface

interface tup_out_if import tup_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [COLOR_W-1:0]  pixel_color;
  logic                visible;
  logic                last_of_item;

  modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last_of_item,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last_of_item,
                  output ready);
endinterface

// ===== hw/rtl/tup_palette.sv =====
// Palette memory: one write port and two read ports with registered read data.
// Depends on tup_pkg for the colour width.
module tup_palette import tup_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [COLOR_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr0_i,
  input  logic [AW-1:0]      raddr1_i,
  output logic [COLOR_W-1:0] rdata0_o,
  output logic [COLOR_W-1:0] rdata1_o
);

  logic [COLOR_W-1:0] mem_q [DEPTH];
  logic [COLOR_W-1:0] rdata0_q;
  logic [COLOR_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== hw/rtl/tup_walk.sv =====
// Tile walk counters: column and row within the tile, and the tile origin.
// Gives the position and visibility of the next pixel. Depends on tup_pkg.
module tup_walk import tup_pkg::*; #(
  parameter int unsigned TILE_ROWS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COORD_W-1:0] image_width_i,
  input  logic [COORD_W-1:0] image_height_i,
  input  logic [TW_W-1:0]    tile_width_i,
  input  walk_ctrl_t         ctrl_i,
  output walk_pos_t          pos_o
);

  localparam int unsigned RowW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int unsigned ColW = $clog2(MAX_TILE_W);

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [COORD_W-1:0] ox_q, ox_d;
  logic [COORD_W-1:0] oy_q, oy_d;

  logic [TW_W-1:0]    tw;
  logic [COORD_W:0]   x_full;
  logic [COORD_W:0]   y_full;
  logic [TW_W-1:0]    col_inc;
  logic [RowW:0]      row_inc;
  logic [COORD_W:0]   nx;

  always_comb begin
    if (tile_width_i == '0) begin
      tw = TW_W'(1);
    end else if (tile_width_i > TW_W'(MAX_TILE_W)) begin
      tw = TW_W'(MAX_TILE_W);
    end else begin
      tw = tile_width_i;
    end
  end

  // Visibility is judged on the unmasked sums.
  assign x_full  = {1'b0, ox_q} + (COORD_W+1)'(col_q);
  assign y_full  = {1'b0, oy_q} + (COORD_W+1)'(row_q);
  assign col_inc = {1'b0, col_q} + TW_W'(1);
  assign row_inc = {1'b0, row_q} + (RowW+1)'(1);
  assign nx      = {1'b0, ox_q} + (COORD_W+1)'(tw);

  assign pos_o.x       = x_full[COORD_W-1:0];
  assign pos_o.y       = y_full[COORD_W-1:0];
  assign pos_o.visible = (x_full < {1'b0, image_width_i}) &&
                         (y_full < {1'b0, image_height_i});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ox_d  = ox_q;
    oy_d  = oy_q;
    if (ctrl_i.restart) begin
      col_d = '0;
      row_d = '0;
      ox_d  = '0;
      oy_d  = '0;
    end else if (ctrl_i.load) begin
      col_d = col_inc[ColW-1:0];
      if (col_inc >= tw) begin
        col_d = '0;
        row_d = row_inc[RowW-1:0];
        if (row_inc >= (RowW+1)'(TILE_ROWS)) begin
          row_d = '0;
          if (nx >= {1'b0, image_width_i}) begin
            ox_d = '0;
            oy_d = oy_q + COORD_W'(TILE_ROWS);
          end else begin
            ox_d = nx[COORD_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
    end
  end

endmodule

// ===== hw/rtl/tile_unswizzle_palette_expand.sv =====
// Tile unswizzle with palette expansion. An input transaction is accepted in every cycle in
// which the item stage is free; the palette is read at acceptance (two registered read ports
// of a 256 x 32 memory, so both nibbles of a 4-bit byte are looked up at once) and the
// result register is loaded from the item stage once it is free. In 8-bit indexed and direct
// RGBA modes one pixel item is taken per cycle while the output is not stalled; in 4-bit indexed
// mode each byte holds the item stage until both its results, one per nibble, are loaded, so no
// new byte is taken before the last one is through. Palette writes and restarts give no result;
// a restart resets the walk in order behind earlier pixels. Reset does not clear the palette.
module tile_unswizzle_palette_expand import tup_pkg::*; #(
  parameter int unsigned TILE_ROWS     = 8,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tup_in_if.sink                in_ch_i,
  tup_out_if.source             out_ch_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  typedef enum logic [1:0] {
    KIND_PAL,
    KIND_NIB,
    KIND_RGBA,
    KIND_RESTART
  } kind_e;

  // Configuration registers.
  logic [COORD_W-1:0] image_width_q;
  logic [COORD_W-1:0] image_height_q;
  logic [TW_W-1:0]    tile_width_q;
  logic [MODE_W-1:0]  pixel_mode_q;
  logic [CNT_W-1:0]   palette_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= COORD_W'(256);
      image_height_q  <= COORD_W'(256);
      tile_width_q    <= TW_W'(16);
      pixel_mode_q    <= MODE_IDX8;
      palette_count_q <= CNT_W'(256);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[COORD_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i[COORD_W-1:0];
        REG_TILE_WIDTH:    tile_width_q    <= cfg_data_i[TW_W-1:0];
        REG_PIXEL_MODE:    pixel_mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_PALETTE_COUNT: palette_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Acceptance and decode.
  logic      accept;
  logic      enter;
  kind_e     enter_kind;
  logic      pal_we;
  logic      in_ready;

  assign accept = in_ch_i.valid && in_ready;

  always_comb begin
    enter      = 1'b0;
    enter_kind = KIND_PAL;
    pal_we     = 1'b0;
    case (op_e'(in_ch_i.operation))
      OP_PAL_WRITE: begin
        pal_we = accept && ({1'b0, in_ch_i.palette_slot} < CNT_W'(PALETTE_DEPTH));
      end
      OP_PIXEL: begin
        unique case (mode_e'(pixel_mode_q))
          MODE_IDX8: begin enter = 1'b1; enter_kind = KIND_PAL;  end
          MODE_IDX4: begin enter = 1'b1; enter_kind = KIND_NIB;  end
          MODE_RGBA: begin enter = 1'b1; enter_kind = KIND_RGBA; end
          default: ;
        endcase
      end
      OP_RESTART: begin
        enter      = 1'b1;
        enter_kind = KIND_RESTART;
      end
      default: ;
    endcase
  end

  // Index clamp against the effective palette count.
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] idx0_raw, idx1_raw;
  logic [CNT_W-1:0] idx0, idx1;

  always_comb begin
    if (palette_count_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (palette_count_q > CNT_W'(PALETTE_DEPTH)) begin
      cnt_eff = CNT_W'(PALETTE_DEPTH);
    end else begin
      cnt_eff = palette_count_q;
    end
    if (mode_e'(pixel_mode_q) == MODE_IDX4) begin
      idx0_raw = CNT_W'(in_ch_i.pixel_byte[3:0]);
    end else begin
      idx0_raw = CNT_W'(in_ch_i.pixel_byte);
    end
    idx1_raw = CNT_W'(in_ch_i.pixel_byte[7:4]);
    idx0 = (idx0_raw >= cnt_eff) ? cnt_eff - CNT_W'(1) : idx0_raw;
    idx1 = (idx1_raw >= cnt_eff) ? cnt_eff - CNT_W'(1) : idx1_raw;
  end

  logic [COLOR_W-1:0] rdata0, rdata1;

  tup_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk_i    (clk_i),
    .we_i     (pal_we),
    .waddr_i  (in_ch_i.palette_slot[AW-1:0]),
    .wdata_i  (in_ch_i.color_word),
    .re_i     (accept && enter),
    .raddr0_i (idx0[AW-1:0]),
    .raddr1_i (idx1[AW-1:0]),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  // Item stage: holds one item until all its results are in the result register.
  logic               s1_valid_q, s1_valid_d;
  kind_e              s1_kind_q;
  logic               s1_half_q, s1_half_d;
  logic [COLOR_W-1:0] s1_word_q;
  logic               out_free;
  logic               load_out;
  logic               s1_done;
  logic [COLOR_W-1:0] pix_color;

  assign out_free = !out_ch_o.valid || out_ch_o.ready;
  assign load_out = s1_valid_q && (s1_kind_q != KIND_RESTART) && out_free;
  assign s1_done  = s1_valid_q && ((s1_kind_q == KIND_RESTART) ||
                    (out_free && ((s1_kind_q != KIND_NIB) || s1_half_q)));
  assign in_ready = !s1_valid_q || s1_done;
  assign in_ch_i.ready = in_ready;

  always_comb begin
    case (s1_kind_q)
      KIND_RGBA: pix_color = s1_word_q;
      KIND_NIB:  pix_color = s1_half_q ? rdata1 : rdata0;
      default:   pix_color = rdata0;
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_half_d  = s1_half_q;
    if (s1_done) begin
      s1_valid_d = 1'b0;
      s1_half_d  = 1'b0;
    end else if (load_out && (s1_kind_q == KIND_NIB)) begin
      s1_half_d = 1'b1;
    end
    if (accept && enter) begin
      s1_valid_d = 1'b1;
      s1_half_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_half_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_half_q  <= s1_half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && enter) begin
      s1_kind_q <= enter_kind;
      s1_word_q <= in_ch_i.color_word;
    end
  end

  // Walk counters.
  walk_ctrl_t walk_ctrl;
  walk_pos_t  walk_pos;

  assign walk_ctrl.load    = load_out;
  assign walk_ctrl.restart = s1_valid_q && (s1_kind_q == KIND_RESTART);

  tup_walk #(
    .TILE_ROWS (TILE_ROWS)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .tile_width_i   (tile_width_q),
    .ctrl_i         (walk_ctrl),
    .pos_o          (walk_pos)
  );

  // Result register.
  logic               out_valid_q;
  logic [COORD_W-1:0] out_x_q;
  logic [COORD_W-1:0] out_y_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_visible_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q       <= walk_pos.x;
      out_y_q       <= walk_pos.y;
      out_color_q   <= pix_color;
      out_visible_q <= walk_pos.visible;
      out_last_q    <= (s1_kind_q != KIND_NIB) || s1_half_q;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.pixel_x      = out_x_q;
  assign out_ch_o.pixel_y      = out_y_q;
  assign out_ch_o.pixel_color  = out_color_q;
  assign out_ch_o.visible      = out_visible_q;
  assign out_ch_o.last_of_item = out_last_q;

  // The second half of a 4-bit byte belongs only to a 4-bit item.
  a_half_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_half_q |-> (s1_valid_q && (s1_kind_q == KIND_NIB)))
    else $error("second-half flag set outside a 4-bit item");

  // A shown first half always has its second half waiting in the item stage.
  a_first_half_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (s1_valid_q && s1_half_q))
    else $error("first half shown without its second half pending");

  // A restart brings the walk back to the image origin.
  a_restart_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_ctrl.restart |=> ((walk_pos.x == '0) && (walk_pos.y == '0)))
    else $error("walk not at origin after restart");

endmodule
